// File: design/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
`default_nettype none
package ffha_pkg;
  localparam int unsigned HdrBytes = 16;
  localparam int unsigned MinSplit = 16;

  typedef enum logic [2:0] {
    ST_ALLOC   = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_ZERO    = 3'd2,
    ST_FREED   = 3'd3,
    ST_NULL    = 3'd4,
    ST_INVALID = 3'd5
  } status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] REG_HEAP_BASE = 2'd0;

  typedef struct packed {
    logic        opcode;
    logic [15:0] request_bytes;
    logic [31:0] release_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] payload_address;
  } out_item_t;
endpackage
`default_nettype wire

// File: design/ffha_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

// File: design/first_fit_heap_allocator.sv
// Top level: block table walker, split and coalesce sequencer, APB register.
// Allocate visits each block in turn (read, wait, check) and writes the split
// remainder in a further state; free checks the freed block and the next one,
// then walks from the start to find the predecessor. One item is in work at a
// time; the registered table read sets the pace. After reset a clearing pass
// writes every table entry before input is accepted. heap_base resets to zero.
`default_nettype none
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ffha_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ffha_pkg::out_item_t     out_data,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [1:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  import ffha_pkg::*;

  localparam int unsigned Units = HEAP_BYTES / 8;
  localparam int unsigned UW    = $clog2(Units);
  localparam int unsigned OW    = UW + 3;
  localparam logic [OW:0] Span  = (OW+1)'(Units * 8);
  // Entry: start bit, free bit, payload size in bytes.
  localparam int unsigned EW    = OW + 2;

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_ARD   = 14'b00000000000100,
    S_AWT   = 14'b00000000001000,
    S_ACHK  = 14'b00000000010000,
    S_ASPL  = 14'b00000000100000,
    S_FRD   = 14'b00000001000000,
    S_FWT   = 14'b00000010000000,
    S_FCHK  = 14'b00000100000000,
    S_FNWT  = 14'b00001000000000,
    S_FNCHK = 14'b00010000000000,
    S_PWT   = 14'b00100000000000,
    S_PCHK  = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [31:0] base_r;
  logic [OW:0] off_r, off_nxt;       // block under work
  logic [OW:0] cur_r, cur_nxt;       // walk pointer
  logic [OW:0] prev_r, prev_nxt;
  logic        have_prev_r, have_prev_nxt;
  logic [OW:0] need_r, need_nxt;
  logic [OW-1:0] size_r, size_nxt;   // size of freed block after next merge, or of the split remainder
  logic [2:0]  st_r, st_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic        phase_r, phase_nxt;   // second step of a two-step state (read wait or second write)
  logic [UW:0] clr_r, clr_nxt;

  logic          we;
  logic [UW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic          e_start, e_free;
  logic [OW-1:0] e_size;

  ffha_ram #(.WIDTH(EW), .DEPTH(Units)) u_tbl (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign e_start = rdata[EW-1];
  assign e_free  = rdata[EW-2];
  assign e_size  = rdata[OW-1:0];

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = (state_r == S_OUT);
  assign out_data   = '{status: st_r, payload_address: addr_r};
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_HEAP_BASE) ? base_r : 32'd0;

  // Shared adder: next block offset = cur + header + size.
  logic [OW:0] nxt_off;
  assign nxt_off = cur_r + (OW+1)'(HdrBytes) + {1'b0, e_size};

  logic [31:0] rel_off;
  logic [16:0] need_calc;
  assign rel_off   = in_data.release_address - {base_r[31:3], 3'b000} - 32'(HdrBytes);
  assign need_calc = ({1'b0, in_data.request_bytes} + 17'd7) & ~17'd7;

  always_comb begin
    state_nxt = state_r;
    off_nxt = off_r; cur_nxt = cur_r; prev_nxt = prev_r;
    have_prev_nxt = have_prev_r; need_nxt = need_r; size_nxt = size_r;
    st_nxt = st_r; addr_nxt = addr_r; phase_nxt = phase_r; clr_nxt = clr_r;
    we = 1'b0; waddr = '0; wdata = '0;
    raddr = cur_r[OW-1:3];
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr_r[UW-1:0];
        wdata = (clr_r == '0) ? {2'b11, OW'(Span - (OW+1)'(HdrBytes))} : '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (UW+1)'(Units - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        phase_nxt = 1'b0;
        if (in_valid) begin
          addr_nxt = 32'd0;
          cur_nxt = '0;
          have_prev_nxt = 1'b0;
          if (in_data.opcode == OP_ALLOC) begin
            if (in_data.request_bytes == 16'd0) begin
              st_nxt = ST_ZERO; state_nxt = S_OUT;
            end else if (32'(need_calc) > 32'(Units * 8)) begin
              // A request larger than the whole heap cannot fit anywhere.
              st_nxt = ST_NOFIT; state_nxt = S_OUT;
            end else begin
              need_nxt = (OW+1)'(need_calc);
              state_nxt = S_ARD;
            end
          end else if (in_data.release_address == 32'd0) begin
            st_nxt = ST_NULL; state_nxt = S_OUT;
          end else if (rel_off >= 32'(Units * 8) || rel_off[2:0] != 3'd0) begin
            st_nxt = ST_INVALID; state_nxt = S_OUT;
          end else begin
            off_nxt = (OW+1)'(rel_off);
            cur_nxt = (OW+1)'(rel_off);
            state_nxt = S_FRD;
          end
        end
      end
      S_ARD: begin
        if (cur_r >= Span) begin
          st_nxt = ST_NOFIT; state_nxt = S_OUT;
        end else state_nxt = S_AWT;
      end
      S_AWT: state_nxt = S_ACHK;
      S_ACHK: begin
        if (e_free && {1'b0, e_size} >= need_r) begin
          off_nxt = cur_r;
          addr_nxt = {base_r[31:3], 3'b000} + 32'(cur_r) + 32'(HdrBytes);
          st_nxt = ST_ALLOC;
          we = 1'b1; waddr = cur_r[OW-1:3];
          if ({1'b0, e_size} >= need_r + (OW+1)'(HdrBytes + MinSplit)) begin
            wdata = {2'b10, need_r[OW-1:0]};
            size_nxt = e_size - need_r[OW-1:0] - OW'(HdrBytes);
            state_nxt = S_ASPL;
          end else begin
            wdata = {2'b10, e_size};
            state_nxt = S_OUT;
          end
        end else begin
          cur_nxt = nxt_off;
          state_nxt = S_ARD;
        end
      end
      S_ASPL: begin
        we = 1'b1;
        waddr = UW'((off_r + (OW+1)'(HdrBytes) + need_r) >> 3);
        wdata = {2'b11, size_r};
        state_nxt = S_OUT;
      end
      S_FRD: state_nxt = S_FWT;
      S_FWT: state_nxt = S_FCHK;
      S_FCHK: begin
        if (!e_start || e_free) begin
          st_nxt = ST_INVALID; state_nxt = S_OUT;
        end else begin
          size_nxt = e_size;
          cur_nxt = nxt_off;
          state_nxt = S_FNWT;
        end
      end
      S_FNWT: begin
        if (cur_r >= Span) begin
          cur_nxt = '0; state_nxt = S_PWT;
        end else if (phase_r) begin
          phase_nxt = 1'b0; state_nxt = S_FNCHK;
        end else phase_nxt = 1'b1;
      end
      S_FNCHK: begin
        if (e_free) begin
          size_nxt = size_r + OW'(HdrBytes) + e_size;
          we = 1'b1; waddr = cur_r[OW-1:3]; wdata = '0;
        end
        cur_nxt = '0;
        state_nxt = S_PWT;
      end
      S_PWT: begin
        // Walk to find the predecessor; phase gives the read its latency.
        if (cur_r >= off_r) begin
          if (have_prev_r) begin
            raddr = prev_r[OW-1:3];
            if (phase_r) begin
              phase_nxt = 1'b0; state_nxt = S_PCHK;
            end else phase_nxt = 1'b1;
          end else begin
            we = 1'b1; waddr = off_r[OW-1:3]; wdata = {2'b11, size_r};
            st_nxt = ST_FREED; state_nxt = S_OUT;
          end
        end else if (phase_r) begin
          phase_nxt = 1'b0;
          prev_nxt = cur_r; have_prev_nxt = 1'b1;
          cur_nxt = nxt_off;
        end else phase_nxt = 1'b1;
      end
      S_PCHK: begin
        raddr = prev_r[OW-1:3];
        st_nxt = ST_FREED;
        if (!phase_r) begin
          we = 1'b1;
          if (e_free) begin
            waddr = prev_r[OW-1:3];
            wdata = {2'b11, e_size + OW'(HdrBytes) + size_r};
            phase_nxt = 1'b1;
          end else begin
            waddr = off_r[OW-1:3]; wdata = {2'b11, size_r};
            state_nxt = S_OUT;
          end
        end else begin
          we = 1'b1; waddr = off_r[OW-1:3]; wdata = '0;
          phase_nxt = 1'b0; state_nxt = S_OUT;
        end
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      base_r <= 32'd0;
      clr_r <= '0;
      phase_r <= 1'b0;
      have_prev_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      phase_r <= phase_nxt;
      have_prev_r <= have_prev_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_HEAP_BASE) begin
        base_r <= cfg_pwdata;
      end
    end
    off_r <= off_nxt; cur_r <= cur_nxt; prev_r <= prev_nxt;
    need_r <= need_nxt; size_r <= size_nxt; st_r <= st_nxt; addr_r <= addr_nxt;
  end
endmodule
`default_nettype wire

// File: design/ffha_checker.sv
// Port-level checker for the allocator, bound to the top level.
`default_nettype none
module ffha_props (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire ffha_pkg::out_item_t out_data
);
  import ffha_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while a result is pending");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_INVALID) else $error("bad status");
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_ALLOC |-> out_data.payload_address == 32'd0)
    else $error("address without allocation");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
endmodule

bind first_fit_heap_allocator ffha_props u_ffha_props (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
